[rtl/hwb_pkg.sv]
// ----------------------------------------------------------------------------
// hwb_pkg: shared types and constants for the homography warp bounds block
// Beat payload structs, result kinds, divider widths and saturation limits.
// ----------------------------------------------------------------------------
package hwb_pkg;

  localparam int VAL_W  = 64;
  localparam int DIM_W  = 14;
  // quotient bits kept by the divider before saturation to VAL_W
  localparam int QUO_W  = 65;
  // divider latency: operand stage, one stage per quotient bit, result stage
  localparam int DIV_LAT = QUO_W + 2;

  localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  // corners in order (-,-) (+,-) (+,+) (-,+): bit c set where the sign is +
  localparam logic [3:0] SX_POS = 4'b0110;
  localparam logic [3:0] SY_POS = 4'b1100;

  typedef enum logic [1:0] {
    KIND_SHIFT  = 2'd0,
    KIND_ROW    = 2'd1,
    KIND_CORNER = 2'd2
  } kind_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] coef_r0c0;
    logic signed [VAL_W-1:0] coef_r0c1;
    logic signed [VAL_W-1:0] coef_r0c2;
    logic signed [VAL_W-1:0] coef_r1c0;
    logic signed [VAL_W-1:0] coef_r1c1;
    logic signed [VAL_W-1:0] coef_r1c2;
    logic signed [VAL_W-1:0] coef_r2c0;
    logic signed [VAL_W-1:0] coef_r2c1;
    logic signed [VAL_W-1:0] coef_r2c2;
    logic [DIM_W-1:0]        image_width;
    logic [DIM_W-1:0]        image_height;
  } in_t;

  typedef struct packed {
    kind_t                   kind;
    logic [1:0]              index;
    logic signed [VAL_W-1:0] value_a;
    logic signed [VAL_W-1:0] value_b;
    logic signed [VAL_W-1:0] value_c;
    logic signed [VAL_W-1:0] value_d;
    logic                    degenerate;
    logic                    last;
  } out_t;

  // recentred matrix carried alongside the corner dividers, row major
  typedef struct packed {
    logic [8:0][VAL_W-1:0] b;
  } cside_t;

  // per-item results carried alongside the row dividers
  typedef struct packed {
    logic                  deg;
    logic [VAL_W-1:0]      shx;
    logic [VAL_W-1:0]      shy;
    logic [VAL_W-1:0]      szx;
    logic [VAL_W-1:0]      szy;
    logic [3:0][VAL_W-1:0] px;
    logic [3:0][VAL_W-1:0] py;
  } rside_t;

  // complete result set of one item, held while its beats drain
  typedef struct packed {
    logic                       deg;
    logic [VAL_W-1:0]           shx;
    logic [VAL_W-1:0]           shy;
    logic [VAL_W-1:0]           szx;
    logic [VAL_W-1:0]           szy;
    logic [2:0][2:0][VAL_W-1:0] t;
    logic [3:0][VAL_W-1:0]      px;
    logic [3:0][VAL_W-1:0]      py;
  } res_t;

endpackage

[rtl/hwb_div.sv]
// ----------------------------------------------------------------------------
// hwb_div: pipelined signed divider with 64-bit saturating quotient
// One quotient bit per stage, truncation toward zero, zero divisor flagged.
// ----------------------------------------------------------------------------
module hwb_div #(
  parameter int NUM_W = 128,
  parameter int DEN_W = 64
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [NUM_W-1:0] num,
  input  logic signed [DEN_W-1:0] den,
  output logic [hwb_pkg::VAL_W-1:0] quo,
  output logic                    zero_div
);

  localparam int QW = hwb_pkg::QUO_W;

  typedef struct packed {
    logic neg;
    logic dz;
    logic nz;
    logic nneg;
    logic ovf;
  } dflags_t;

  logic [NUM_W-1:0] nm_c;
  logic [NUM_W-1:0] hi_c;
  logic [DEN_W-1:0] dm_c;
  dflags_t          fl_c;

  logic [DEN_W-1:0] rem_r [QW+1];
  logic [QW-1:0]    lo_r  [QW+1];
  logic [QW-1:0]    q_r   [QW+1];
  logic [DEN_W-1:0] dm_r  [QW+1];
  dflags_t          fl_r  [QW+1];

  logic [hwb_pkg::VAL_W-1:0] quo_nxt;
  logic [hwb_pkg::VAL_W-1:0] quo_r;
  logic                      dz_r;
  logic [QW-1:0]             qneg;

  // take magnitudes and spot quotients too large to resolve
  always_comb begin
    nm_c     = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    dm_c     = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
    hi_c     = nm_c >> QW;
    fl_c.neg  = num[NUM_W-1] ^ den[DEN_W-1];
    fl_c.dz   = (den == '0);
    fl_c.nz   = (num == '0);
    fl_c.nneg = num[NUM_W-1];
    fl_c.ovf  = (hi_c >= NUM_W'(dm_c));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= hi_c[DEN_W-1:0];
      lo_r[0]  <= nm_c[QW-1:0];
      q_r[0]   <= '0;
      dm_r[0]  <= dm_c;
      fl_r[0]  <= fl_c;
    end
  end

  // restoring step: one quotient bit per stage
  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           ge;
    always_comb begin
      trial = {rem_r[k], lo_r[k][QW-1]};
      diff  = trial - {1'b0, dm_r[k]};
      ge    = (trial >= {1'b0, dm_r[k]});
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        lo_r[k+1]  <= {lo_r[k][QW-2:0], 1'b0};
        q_r[k+1]   <= {q_r[k][QW-2:0], ge};
        dm_r[k+1]  <= dm_r[k];
        fl_r[k+1]  <= fl_r[k];
      end
    end
  end

  // apply sign and saturate to the result width
  always_comb begin
    qneg = QW'(-q_r[QW]);
    if (fl_r[QW].dz) begin
      quo_nxt = fl_r[QW].nz ? '0 : (fl_r[QW].nneg ? hwb_pkg::VAL_MIN : hwb_pkg::VAL_MAX);
    end else if (fl_r[QW].ovf) begin
      quo_nxt = fl_r[QW].neg ? hwb_pkg::VAL_MIN : hwb_pkg::VAL_MAX;
    end else if (!fl_r[QW].neg) begin
      quo_nxt = (q_r[QW][QW-1:hwb_pkg::VAL_W-1] != '0) ? hwb_pkg::VAL_MAX
                                                       : q_r[QW][hwb_pkg::VAL_W-1:0];
    end else begin
      quo_nxt = (q_r[QW] > QW'(hwb_pkg::VAL_MIN)) ? hwb_pkg::VAL_MIN
                                                  : qneg[hwb_pkg::VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo_r <= quo_nxt;
      dz_r  <= fl_r[QW].dz;
    end
  end

  assign quo      = quo_r;
  assign zero_div = dz_r;

endmodule

[rtl/homography_warp_bounds_top.sv]
// ----------------------------------------------------------------------------
// homography_warp_bounds_top: corner bounding box of a projective warp
// Maps the four image corners, gives shift and size, the recentred matrix
// rows and the shifted integer corners as eight result beats per image.
// ----------------------------------------------------------------------------
// Flow: each image gives the eight beats of the result channel; the pipeline
//   (two rows of bit-per-stage dividers) takes a beat every cycle and holds as
//   a whole while the result buffer is full and its tail holds an image.
// Reset: synchronous, active low; clears valid bits and the beat counter.
module homography_warp_bounds_top #(
  parameter int FRAC_BITS = 32,
  parameter int DIM_BITS  = 14
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  hwb_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output hwb_pkg::out_t  out_data
);

  localparam int VW  = hwb_pkg::VAL_W;
  localparam int DU  = (DIM_BITS < hwb_pkg::DIM_W) ? DIM_BITS : hwb_pkg::DIM_W;
  localparam int PW  = VW + DU + 1;
  localparam int CW  = PW + 2;
  localparam int CNW = CW + FRAC_BITS;
  localparam int TNW = 2 * VW;
  localparam int LD  = hwb_pkg::DIV_LAT;
  localparam int RL  = LD + 4;
  localparam logic [2:0]  LAST_BEAT = 3'd7;
  localparam logic [VW:0] FMASK = ~(((VW+1)'(1)) << FRAC_BITS) + (VW+1)'(1);

  function automatic logic signed [VW-1:0] smin(input logic signed [VW-1:0] a,
                                                input logic signed [VW-1:0] b);
    smin = (b < a) ? b : a;
  endfunction

  function automatic logic signed [VW-1:0] smax(input logic signed [VW-1:0] a,
                                                input logic signed [VW-1:0] b);
    smax = (a < b) ? b : a;
  endfunction

  logic adv;
  logic buf_take;

  // ---------------- stage 1: input register
  logic                 s1_vld_r;
  logic signed [VW-1:0] s1_m_r [9];
  logic [DU-1:0]        s1_w_r;
  logic [DU-1:0]        s1_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_m_r[0] <= in_data.coef_r0c0;
      s1_m_r[1] <= in_data.coef_r0c1;
      s1_m_r[2] <= in_data.coef_r0c2;
      s1_m_r[3] <= in_data.coef_r1c0;
      s1_m_r[4] <= in_data.coef_r1c1;
      s1_m_r[5] <= in_data.coef_r1c2;
      s1_m_r[6] <= in_data.coef_r2c0;
      s1_m_r[7] <= in_data.coef_r2c1;
      s1_m_r[8] <= in_data.coef_r2c2;
      s1_w_r    <= in_data.image_width[DU-1:0];
      s1_h_r    <= in_data.image_height[DU-1:0];
    end
  end

  // ---------------- stage 2: scale columns 0 and 1 by width and height
  logic                 s2_vld_r;
  logic signed [PW-1:0] s2_p0_r [3];
  logic signed [PW-1:0] s2_p1_r [3];
  logic signed [VW-1:0] s2_m_r  [9];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        s2_p0_r[r] <= PW'(s1_m_r[3*r])   * PW'($signed({1'b0, s1_w_r}));
        s2_p1_r[r] <= PW'(s1_m_r[3*r+1]) * PW'($signed({1'b0, s1_h_r}));
      end
      s2_m_r <= s1_m_r;
    end
  end

  // ---------------- stage 3: corner sums and recentred column 2
  logic signed [CW-1:0] cs_nxt [4][3];
  logic signed [CW-1:0] half_c [3];
  logic signed [CW-1:0] htop_c [3];
  logic [VW-1:0]        b2_c   [3];
  logic signed [CW-1:0] s3_cs_r [4][3];
  logic [LD:0]          cvld_r;
  hwb_pkg::cside_t      cside_r [LD+1];

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 3; r++) begin
        cs_nxt[c][r] = (hwb_pkg::SX_POS[c] ? CW'(s2_p0_r[r]) : -CW'(s2_p0_r[r]))
                     + (hwb_pkg::SY_POS[c] ? CW'(s2_p1_r[r]) : -CW'(s2_p1_r[r]))
                     + (CW'(s2_m_r[3*r+2]) <<< 1);
      end
    end
    // corner (-,-) holds twice the recentred entry; halve and saturate
    for (int r = 0; r < 3; r++) begin
      half_c[r] = cs_nxt[0][r] >>> 1;
      htop_c[r] = half_c[r] >>> (VW - 1);
      if (htop_c[r] == {CW{1'b0}} || htop_c[r] == {CW{1'b1}}) begin
        b2_c[r] = half_c[r][VW-1:0];
      end else begin
        b2_c[r] = half_c[r][CW-1] ? hwb_pkg::VAL_MIN : hwb_pkg::VAL_MAX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cvld_r <= '0;
    end else if (adv) begin
      cvld_r <= {cvld_r[LD-1:0], s2_vld_r};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_cs_r <= cs_nxt;
      cside_r[0].b <= {b2_c[2], s2_m_r[7], s2_m_r[6],
                       b2_c[1], s2_m_r[4], s2_m_r[3],
                       b2_c[0], s2_m_r[1], s2_m_r[0]};
      for (int k = 1; k <= LD; k++) begin
        cside_r[k] <= cside_r[k-1];
      end
    end
  end

  // ---------------- corner dividers: x and y of each corner
  logic [VW-1:0] cq  [4][2];
  logic [7:0]    cdz;

  for (genvar c = 0; c < 4; c++) begin : g_cdiv
    for (genvar a = 0; a < 2; a++) begin : g_axis
      hwb_div #(
        .NUM_W (CNW),
        .DEN_W (CW)
      ) u_div (
        .clk      (clk),
        .en       (adv),
        .num      ($signed({s3_cs_r[c][a], {FRAC_BITS{1'b0}}})),
        .den      (s3_cs_r[c][2]),
        .quo      (cq[c][a]),
        .zero_div (cdz[2*c+a])
      );
    end
  end

  // ---------------- stage M1: minimum and maximum of the corners
  logic                 sm1_vld_r;
  logic signed [VW-1:0] sm1_mnx_r, sm1_mxx_r, sm1_mny_r, sm1_mxy_r;
  logic [VW-1:0]        sm1_cx_r [4];
  logic [VW-1:0]        sm1_cy_r [4];
  logic [8:0][VW-1:0]   sm1_b_r;
  logic                 sm1_deg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sm1_vld_r <= 1'b0;
    end else if (adv) begin
      sm1_vld_r <= cvld_r[LD];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sm1_mnx_r <= smin(smin(cq[0][0], cq[1][0]), smin(cq[2][0], cq[3][0]));
      sm1_mxx_r <= smax(smax(cq[0][0], cq[1][0]), smax(cq[2][0], cq[3][0]));
      sm1_mny_r <= smin(smin(cq[0][1], cq[1][1]), smin(cq[2][1], cq[3][1]));
      sm1_mxy_r <= smax(smax(cq[0][1], cq[1][1]), smax(cq[2][1], cq[3][1]));
      for (int c = 0; c < 4; c++) begin
        sm1_cx_r[c] <= cq[c][0];
        sm1_cy_r[c] <= cq[c][1];
      end
      sm1_b_r   <= cside_r[LD].b;
      sm1_deg_r <= |cdz;
    end
  end

  // ---------------- stage M2: shift and size
  logic [VW:0]          dx_c, dy_c;
  logic                 sm2_vld_r;
  logic [VW-1:0]        sm2_shx_r, sm2_shy_r, sm2_szx_r, sm2_szy_r;
  logic [VW-1:0]        sm2_cx_r [4];
  logic [VW-1:0]        sm2_cy_r [4];
  logic [8:0][VW-1:0]   sm2_b_r;
  logic                 sm2_deg_r;

  always_comb begin
    dx_c = {sm1_mxx_r[VW-1], sm1_mxx_r} - {sm1_mnx_r[VW-1], sm1_mnx_r};
    dy_c = {sm1_mxy_r[VW-1], sm1_mxy_r} - {sm1_mny_r[VW-1], sm1_mny_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sm2_vld_r <= 1'b0;
    end else if (adv) begin
      sm2_vld_r <= sm1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sm2_shx_r <= (sm1_mnx_r == hwb_pkg::VAL_MIN) ? hwb_pkg::VAL_MAX : VW'(-sm1_mnx_r);
      sm2_shy_r <= (sm1_mny_r == hwb_pkg::VAL_MIN) ? hwb_pkg::VAL_MAX : VW'(-sm1_mny_r);
      sm2_szx_r <= (dx_c[VW:VW-1] != 2'b00) ? hwb_pkg::VAL_MAX : dx_c[VW-1:0];
      sm2_szy_r <= (dy_c[VW:VW-1] != 2'b00) ? hwb_pkg::VAL_MAX : dy_c[VW-1:0];
      sm2_cx_r  <= sm1_cx_r;
      sm2_cy_r  <= sm1_cy_r;
      sm2_b_r   <= sm1_b_r;
      sm2_deg_r <= sm1_deg_r;
    end
  end

  // ---------------- stage M3: integer corners and product magnitudes
  logic [VW-1:0]        pxy_c [4][2];
  logic [VW-1:0]        ma_c  [6];
  logic [VW-1:0]        mb_c  [6];
  logic [5:0]           sg_c;
  logic [VW-1:0]        m1_ma_r [6];
  logic [VW-1:0]        m1_mb_r [6];
  logic [5:0]           m1_sg_r;
  logic [8:0][VW-1:0]   m1_b_r;
  logic [RL-1:0]        rvld_r;
  hwb_pkg::rside_t      rside_r [RL];

  always_comb begin
    logic [VW:0]   v;
    logic [VW:0]   av;
    logic [VW:0]   tv;
    logic [VW-1:0] sh;
    logic [VW-1:0] cc;
    logic [VW-1:0] aa;
    logic [VW-1:0] bb;
    v = '0; av = '0; tv = '0; sh = '0; cc = '0; aa = '0; bb = '0;
    // cut shifted corners toward zero to whole pixels, then saturate
    for (int c = 0; c < 4; c++) begin
      for (int a = 0; a < 2; a++) begin
        sh = (a == 0) ? sm2_shx_r : sm2_shy_r;
        cc = (a == 0) ? sm2_cx_r[c] : sm2_cy_r[c];
        v  = {cc[VW-1], cc} + {sh[VW-1], sh};
        av = v[VW] ? (VW+1)'(-v) : v;
        av = av & FMASK;
        tv = v[VW] ? (VW+1)'(-av) : av;
        if (tv[VW] != tv[VW-1]) begin
          pxy_c[c][a] = v[VW] ? hwb_pkg::VAL_MIN : hwb_pkg::VAL_MAX;
        end else begin
          pxy_c[c][a] = tv[VW-1:0];
        end
      end
    end
    // magnitudes of shift times row 2, rows 0 and 1
    for (int k = 0; k < 6; k++) begin
      aa = (k < 3) ? sm2_shx_r : sm2_shy_r;
      bb = sm2_b_r[6 + (k % 3)];
      ma_c[k] = aa[VW-1] ? VW'(-aa) : aa;
      mb_c[k] = bb[VW-1] ? VW'(-bb) : bb;
      sg_c[k] = aa[VW-1] ^ bb[VW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rvld_r <= '0;
    end else if (adv) begin
      rvld_r <= {rvld_r[RL-2:0], sm2_vld_r};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_ma_r <= ma_c;
      m1_mb_r <= mb_c;
      m1_sg_r <= sg_c;
      m1_b_r  <= sm2_b_r;
      rside_r[0].deg <= sm2_deg_r;
      rside_r[0].shx <= sm2_shx_r;
      rside_r[0].shy <= sm2_shy_r;
      rside_r[0].szx <= sm2_szx_r;
      rside_r[0].szy <= sm2_szy_r;
      for (int c = 0; c < 4; c++) begin
        rside_r[0].px[c] <= pxy_c[c][0];
        rside_r[0].py[c] <= pxy_c[c][1];
      end
      for (int k = 1; k < RL; k++) begin
        rside_r[k] <= rside_r[k-1];
      end
    end
  end

  // ---------------- stage M4: 32x32 partial products
  logic [VW-1:0]        m2_pp_r [6][4];
  logic [5:0]           m2_sg_r;
  logic [8:0][VW-1:0]   m2_b_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 6; k++) begin
        m2_pp_r[k][0] <= VW'(m1_ma_r[k][31:0])  * VW'(m1_mb_r[k][31:0]);
        m2_pp_r[k][1] <= VW'(m1_ma_r[k][31:0])  * VW'(m1_mb_r[k][63:32]);
        m2_pp_r[k][2] <= VW'(m1_ma_r[k][63:32]) * VW'(m1_mb_r[k][31:0]);
        m2_pp_r[k][3] <= VW'(m1_ma_r[k][63:32]) * VW'(m1_mb_r[k][63:32]);
      end
      m2_sg_r <= m1_sg_r;
      m2_b_r  <= m1_b_r;
    end
  end

  // ---------------- stage M5: sum partials
  logic [TNW-1:0]       m3_sum_r [6];
  logic [5:0]           m3_sg_r;
  logic [8:0][VW-1:0]   m3_b_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 6; k++) begin
        m3_sum_r[k] <= {64'd0, m2_pp_r[k][0]}
                     + {32'd0, m2_pp_r[k][1], 32'd0}
                     + {32'd0, m2_pp_r[k][2], 32'd0}
                     + {m2_pp_r[k][3], 64'd0};
      end
      m3_sg_r <= m2_sg_r;
      m3_b_r  <= m2_b_r;
    end
  end

  // ---------------- stage M6: row numerators and divisor
  logic signed [TNW-1:0] m4_num_r [9];
  logic signed [VW-1:0]  m4_den_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        for (int r = 0; r < 2; r++) begin
          m4_num_r[3*r+j] <= (TNW'($signed(m3_b_r[3*r+j])) <<< FRAC_BITS)
                           + (m3_sg_r[3*r+j] ? TNW'(-m3_sum_r[3*r+j]) : m3_sum_r[3*r+j]);
        end
        m4_num_r[6+j] <= TNW'($signed(m3_b_r[6+j])) <<< FRAC_BITS;
      end
      m4_den_r <= m3_b_r[8];
    end
  end

  // ---------------- row dividers: normalise by entry (2,2)
  logic [VW-1:0] rq [9];
  logic [8:0]    rdz;

  for (genvar k = 0; k < 9; k++) begin : g_rdiv
    hwb_div #(
      .NUM_W (TNW),
      .DEN_W (VW)
    ) u_div (
      .clk      (clk),
      .en       (adv),
      .num      (m4_num_r[k]),
      .den      (m4_den_r),
      .quo      (rq[k]),
      .zero_div (rdz[k])
    );
  end

  // ---------------- result buffer and beat sequencer
  logic          buf_vld_r;
  logic [2:0]    cnt_r;
  logic [2:0]    rsel;
  hwb_pkg::res_t res_r;

  assign buf_take = !buf_vld_r || (out_ready && cnt_r == LAST_BEAT);
  assign adv      = !rvld_r[RL-1] || buf_take;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_vld_r <= 1'b0;
      cnt_r     <= '0;
    end else if (buf_take) begin
      buf_vld_r <= rvld_r[RL-1];
      cnt_r     <= '0;
    end else if (out_ready) begin
      cnt_r <= cnt_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (buf_take && rvld_r[RL-1]) begin
      res_r.deg <= rside_r[RL-1].deg | (|rdz);
      res_r.shx <= rside_r[RL-1].shx;
      res_r.shy <= rside_r[RL-1].shy;
      res_r.szx <= rside_r[RL-1].szx;
      res_r.szy <= rside_r[RL-1].szy;
      res_r.px  <= rside_r[RL-1].px;
      res_r.py  <= rside_r[RL-1].py;
      for (int r = 0; r < 3; r++) begin
        for (int j = 0; j < 3; j++) begin
          res_r.t[r][j] <= rq[3*r+j];
        end
      end
    end
  end

  // pick the beat under the counter
  assign rsel = cnt_r - 3'd1;

  always_comb begin
    out_data            = '0;
    out_data.degenerate = res_r.deg;
    out_data.last       = (cnt_r == LAST_BEAT);
    case (cnt_r) inside
      3'd0: begin
        out_data.kind    = hwb_pkg::KIND_SHIFT;
        out_data.value_a = res_r.shx;
        out_data.value_b = res_r.shy;
        out_data.value_c = res_r.szx;
        out_data.value_d = res_r.szy;
      end
      [3'd1:3'd3]: begin
        out_data.kind    = hwb_pkg::KIND_ROW;
        out_data.index   = rsel[1:0];
        out_data.value_a = res_r.t[rsel[1:0]][0];
        out_data.value_b = res_r.t[rsel[1:0]][1];
        out_data.value_c = res_r.t[rsel[1:0]][2];
      end
      default: begin
        out_data.kind    = hwb_pkg::KIND_CORNER;
        out_data.index   = cnt_r[1:0];
        out_data.value_a = res_r.px[cnt_r[1:0]];
        out_data.value_b = res_r.py[cnt_r[1:0]];
      end
    endcase
  end

  assign out_valid = buf_vld_r;

  // ---------------- assertions
  a_hold_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    rvld_r[RL-1] && buf_vld_r && !(out_ready && cnt_r == LAST_BEAT) |-> !in_ready)
    else $error("pipeline advanced into a full result buffer");

  a_last_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.last ==
                   (out_data.kind == hwb_pkg::KIND_CORNER && out_data.index == 2'd3)))
    else $error("last flag not on the final corner beat");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(buf_vld_r) |-> $past(rvld_r[RL-1]))
    else $error("result buffer filled from an empty pipeline tail");

  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    buf_vld_r && !out_ready |=> $stable(cnt_r))
    else $error("beat counter moved without an accepted beat");

endmodule

[tb/homography_warp_bounds_top_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// homography_warp_bounds_top_test: self-checking bench for the warp bounds block
// Sends images over the input channel with random gaps, works out the eight
// result beats of each image in a local model and compares every beat taken
// from the result channel, field by field, against the oldest one waiting.
// ----------------------------------------------------------------------------
module homography_warp_bounds_top_test;

  typedef logic signed [127:0] wide_t;

  localparam int FRAC        = 32;
  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE      = 300;
  localparam logic [63:0] ONE = 64'h1_0000_0000;

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_ready;
  hwb_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_ready;
  hwb_pkg::out_t out_data;

  hwb_pkg::out_t beats_due[$];
  int     mismatches;
  int     quiet_cycles;
  int     rx_hold;
  bit     calm;

  homography_warp_bounds_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------- model --
  function automatic wide_t sext(logic [63:0] v);
    return wide_t'($signed(v));
  endfunction

  function automatic logic [63:0] clamp64(wide_t v);
    if (v[127:63] == '0 || v[127:63] == '1) return v[63:0];
    return v[127] ? hwb_pkg::VAL_MIN : hwb_pkg::VAL_MAX;
  endfunction

  function automatic logic [63:0] divide_sat(wide_t n, wide_t d, inout bit deg);
    logic [127:0] nm, dm, q;
    if (d == 0) begin
      deg = 1'b1;
      if (n == 0) return '0;
      return n[127] ? hwb_pkg::VAL_MIN : hwb_pkg::VAL_MAX;
    end
    nm = n[127] ? -n : n;
    dm = d[127] ? -d : d;
    q  = nm / dm;
    if (n[127] != d[127]) q = -q;
    return clamp64(q);
  endfunction

  function automatic logic [63:0] whole_pixel(wide_t v);
    logic [127:0] a;
    a = v[127] ? -v : v;
    a[FRAC-1:0] = '0;
    if (v[127]) a = -a;
    return clamp64(a);
  endfunction

  // twice the row dotted with corner (+-w/2, +-h/2, 1)
  function automatic wide_t corner_dot2(logic [63:0] a, logic [63:0] b, logic [63:0] c,
                                        wide_t w, wide_t h, int k);
    wide_t tx, ty;
    tx = sext(a) * w;
    ty = sext(b) * h;
    if (!hwb_pkg::SX_POS[k]) tx = -tx;
    if (!hwb_pkg::SY_POS[k]) ty = -ty;
    return tx + ty + (sext(c) <<< 1);
  endfunction

  // queue the eight beats one image must produce
  function automatic void predict_bounds(hwb_pkg::in_t img);
    logic [63:0] m[9];
    logic [63:0] cx[4], cy[4], rb[3][3], t[3][3];
    logic [63:0] minx, maxx, miny, maxy, shx, shy, szx, szy;
    wide_t w, h, x2, y2, z2, v, num;
    bit deg;
    hwb_pkg::out_t o;
    deg = 1'b0;
    m = '{img.coef_r0c0, img.coef_r0c1, img.coef_r0c2, img.coef_r1c0, img.coef_r1c1,
          img.coef_r1c2, img.coef_r2c0, img.coef_r2c1, img.coef_r2c2};
    w = wide_t'({114'b0, img.image_width});
    h = wide_t'({114'b0, img.image_height});
    for (int k = 0; k < 4; k++) begin
      x2 = corner_dot2(m[0], m[1], m[2], w, h, k);
      y2 = corner_dot2(m[3], m[4], m[5], w, h, k);
      z2 = corner_dot2(m[6], m[7], m[8], w, h, k);
      cx[k] = divide_sat(x2 <<< FRAC, z2, deg);
      cy[k] = divide_sat(y2 <<< FRAC, z2, deg);
    end
    minx = cx[0]; maxx = cx[0]; miny = cy[0]; maxy = cy[0];
    for (int k = 1; k < 4; k++) begin
      if ($signed(cx[k]) < $signed(minx)) minx = cx[k];
      if ($signed(cx[k]) > $signed(maxx)) maxx = cx[k];
      if ($signed(cy[k]) < $signed(miny)) miny = cy[k];
      if ($signed(cy[k]) > $signed(maxy)) maxy = cy[k];
    end
    shx = clamp64(-sext(minx));
    shy = clamp64(-sext(miny));
    szx = clamp64(sext(maxx) - sext(minx));
    szy = clamp64(sext(maxy) - sext(miny));
    // recentre: fold the half-size translation into column 2
    for (int r = 0; r < 3; r++) begin
      v = (sext(m[3*r+2]) <<< 1) - sext(m[3*r]) * w - sext(m[3*r+1]) * h;
      rb[r][0] = m[3*r];
      rb[r][1] = m[3*r+1];
      rb[r][2] = clamp64(v >>> 1);
    end
    for (int r = 0; r < 3; r++) begin
      for (int j = 0; j < 3; j++) begin
        num = sext(rb[r][j]) <<< FRAC;
        if (r == 0) num = num + sext(shx) * sext(rb[2][j]);
        else if (r == 1) num = num + sext(shy) * sext(rb[2][j]);
        t[r][j] = divide_sat(num, sext(rb[2][2]), deg);
      end
    end
    o = '{kind: hwb_pkg::KIND_SHIFT, index: 2'd0, value_a: shx, value_b: shy,
          value_c: szx, value_d: szy, degenerate: deg, last: 1'b0};
    beats_due.push_back(o);
    for (int r = 0; r < 3; r++) begin
      o = '{kind: hwb_pkg::KIND_ROW, index: 2'(r), value_a: t[r][0], value_b: t[r][1],
            value_c: t[r][2], value_d: '0, degenerate: deg, last: 1'b0};
      beats_due.push_back(o);
    end
    for (int k = 0; k < 4; k++) begin
      o = '{kind: hwb_pkg::KIND_CORNER, index: 2'(k),
            value_a: whole_pixel(sext(cx[k]) + sext(shx)),
            value_b: whole_pixel(sext(cy[k]) + sext(shy)),
            value_c: '0, value_d: '0, degenerate: deg, last: (k == 3)};
      beats_due.push_back(o);
    end
  endfunction

  // ------------------------------------------------------------- stimulus --
  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] jitter(int span);
    return 64'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  // plausible homography: near identity, translation, slight perspective
  function automatic hwb_pkg::in_t warp_image(int persp);
    hwb_pkg::in_t img;
    img.coef_r0c0 = ONE + jitter(1 << 30);
    img.coef_r0c1 = jitter(1 << 29);
    img.coef_r0c2 = jitter(1 << 30) <<< 8;
    img.coef_r1c0 = jitter(1 << 29);
    img.coef_r1c1 = ONE + jitter(1 << 30);
    img.coef_r1c2 = jitter(1 << 30) <<< 8;
    img.coef_r2c0 = jitter(persp);
    img.coef_r2c1 = jitter(persp);
    img.coef_r2c2 = ONE + jitter(1 << 28);
    img.image_width  = ($urandom_range(0, 7) == 0) ? 14'($urandom) : 14'($urandom_range(1, 600));
    img.image_height = ($urandom_range(0, 7) == 0) ? 14'($urandom) : 14'($urandom_range(1, 600));
    return img;
  endfunction

  function automatic hwb_pkg::in_t raw_image();
    hwb_pkg::in_t img;
    img = {rand64(), rand64(), rand64(), rand64(), rand64(), rand64(), rand64(),
           rand64(), rand64(), 14'($urandom), 14'($urandom)};
    return img;
  endfunction

  // send one image; valid stays up back to back when no gap is drawn
  task automatic send_image(hwb_pkg::in_t img);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= img;
    do @(posedge clk); while (!in_ready);
    predict_bounds(img);
  endtask

  task automatic test_directed();
    hwb_pkg::in_t img;
    // identity, smallest and largest image
    img = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, 14'd1, 14'd1};
    send_image(img);
    img.image_width = '1; img.image_height = '1;
    send_image(img);
    // zero width or height collapses the corners
    img.image_width = '0; img.image_height = 14'd100;
    send_image(img);
    img.image_width = 14'd100; img.image_height = '0;
    send_image(img);
    // field extremes
    img = '{hwb_pkg::VAL_MAX, hwb_pkg::VAL_MAX, hwb_pkg::VAL_MAX, hwb_pkg::VAL_MAX,
            hwb_pkg::VAL_MAX, hwb_pkg::VAL_MAX, hwb_pkg::VAL_MAX, hwb_pkg::VAL_MAX,
            hwb_pkg::VAL_MAX, '1, '1};
    send_image(img);
    img = '{hwb_pkg::VAL_MIN, hwb_pkg::VAL_MIN, hwb_pkg::VAL_MIN, hwb_pkg::VAL_MIN,
            hwb_pkg::VAL_MIN, hwb_pkg::VAL_MIN, hwb_pkg::VAL_MIN, hwb_pkg::VAL_MIN,
            hwb_pkg::VAL_MIN, '1, '1};
    send_image(img);
    img = '{hwb_pkg::VAL_MIN, hwb_pkg::VAL_MAX, hwb_pkg::VAL_MIN, hwb_pkg::VAL_MAX,
            hwb_pkg::VAL_MIN, hwb_pkg::VAL_MAX, hwb_pkg::VAL_MIN, hwb_pkg::VAL_MAX,
            hwb_pkg::VAL_MIN, 14'h2AAA, 14'h1555};
    send_image(img);
    img = '{'1, '1, '1, '1, '1, '1, '1, '1, '1, 14'd3, 14'd5};
    send_image(img);
    // rotation by ninety degrees with translation
    img = '{0, -ONE, ONE <<< 6, ONE, 0, -(ONE <<< 5), 0, 0, ONE, 14'd640, 14'd480};
    send_image(img);
    // strong perspective, scaled bottom row
    img = '{ONE, 0, 0, 0, ONE, 0, 64'd1 << 24, -(64'd1 << 23), ONE <<< 1, 14'd320, 14'd200};
    send_image(img);
    // zero divisor: all-zero matrix, then an empty bottom row
    img = '0; img.image_width = 14'd8; img.image_height = 14'd8;
    send_image(img);
    img = '{ONE, 0, 0, 0, ONE, 0, 0, 0, 0, 14'd16, 14'd9};
    send_image(img);
    // recentred entry (2,2) cancels to zero, as do the (-,-) and (-,+) corner divisors
    img = '{ONE, 0, 0, 0, ONE, 0, ONE, 0, ONE <<< 5, 14'd64, 14'd64};
    send_image(img);
    // one corner on the horizon line only
    img = '{ONE, 0, 0, 0, ONE, 0, ONE, ONE, ONE <<< 3, 14'd8, 14'd8};
    send_image(img);
    for (int k = 0; k < 4; k++) send_image(raw_image());
  endtask

  task automatic test_random_warps(int count);
    for (int k = 0; k < count; k++) begin
      calm = ($urandom_range(0, 9) == 0);
      case ($urandom_range(0, 9))
        0, 1:    send_image(raw_image());
        2:       send_image(warp_image(1 << 26));
        default: send_image(warp_image(1 << 18));
      endcase
    end
    calm = 1'b0;
  endtask

  task automatic test_burst(int count);
    calm = 1'b1;
    for (int k = 0; k < count; k++) send_image(warp_image(1 << 20));
    calm = 1'b0;
  endtask

  // -------------------------------------------------------------- receiver --
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_hold   <= 0;
    end else if (rx_hold > 0) begin
      rx_hold   <= rx_hold - 1;
      out_ready <= 1'b0;
    end else if (out_ready && out_valid) begin
      // draw the stall before the next beat
      if (calm) begin
        out_ready <= 1'b1;
      end else begin
        automatic int s = $urandom_range(0, 6);
        out_ready <= (s == 0);
        rx_hold   <= (s == 0) ? 0 : s - 1;
      end
    end else begin
      out_ready <= 1'b1;
    end
  end

  // compare each beat with the oldest one waiting
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (beats_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", out_data);
      end else begin
        automatic hwb_pkg::out_t e = beats_due.pop_front();
        if (out_data.kind !== e.kind || out_data.index !== e.index ||
            out_data.value_a !== e.value_a || out_data.value_b !== e.value_b ||
            out_data.value_c !== e.value_c || out_data.value_d !== e.value_d ||
            out_data.degenerate !== e.degenerate || out_data.last !== e.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected %p", e);
            $display("          actual   %p", out_data);
          end
        end
      end
    end
  end

  // stop a hung run
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("homography_warp_bounds_top test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ------------------------------------------------------------- sequence --
  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    mismatches = 0;
    calm       = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_burst(12);
    test_random_warps(130);
    in_valid <= 1'b0;
    // drain, then allow for any stray beat
    while (beats_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("homography_warp_bounds_top test passed");
    end else begin
      $display("homography_warp_bounds_top test failed");
    end
    $finish;
  end

endmodule
